// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the stream beats
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int POSX_W   = 7;
    localparam int POSY_W   = 5;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_CURSOR = 2'd0,
        CMD_PUT_AT     = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCROLL,
        ST_FLUSH,
        ST_BLANK,
        ST_CLEAR,
        ST_CURSOR,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] cell_color;
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
    } item_t;

    typedef struct packed {
        logic [POSX_W-1:0]   write_col;
        logic [POSY_W-1:0]   write_row;
        logic [CURSOR_W-1:0] hw_cursor_pos;
        logic [CELL_W-1:0]   cell_entry;
        logic                scrolled;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`default_nettype none

// Text console engine over a COLUMNS x ROWS screen of 16-bit cells (attribute in the high
// byte, character in the low byte). Each input beat carries a command in tuser: put a
// character at the write position (newline, backspace, wrap and scroll handled), put a
// cell at a given position, clear the screen, or read a cell back. Each input beat yields
// exactly one output beat with the write position, the hardware cursor and, for a read,
// the cell. Operation, with one single-port-write screen memory swept by one address counter:
// after reset the block fills the screen with blanks before it raises s_axis_tready. A put
// passes through ST_CURSOR when it moves the cursor and a read through ST_RD_WAIT when it
// reads a cell; a clear blanks every cell; a put that scrolls copies each row one row up
// and blanks the last row, one cell moved per cycle, then a character put also updates
// the cursor. One item is in work at a time and the next beat can be taken in the cycle
// after a result loads; the output register lets the next item start while a result
// waits. The attribute register should be written through the cfg channel only while
// the block is idle; the block itself does not enforce this.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // char_code[7:0], cell_color[15:8], pos_x[22:16], pos_y[27:23], zero[31:28]
    input  wire logic [31:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // write_col[6:0], write_row[11:7], hw_cursor_pos[22:12], cell_entry[38:23],
    // scrolled[39]
    output logic [39:0]      m_axis_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    // text_attribute
    input  wire logic [7:0]  cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [tcw_pkg::POSY_W-1:0] LAST_ROW_OUT = tcw_pkg::POSY_W'(ROWS - 1);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic                       out_valid_reg;
    tcw_pkg::result_t           out_reg;
    tcw_pkg::item_t             item_in;
    tcw_pkg::result_t           res;
    logic                       res_valid;
    logic                       out_free;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    assign item_in.cmd        = tcw_pkg::cmd_t'(s_axis_tuser);
    assign item_in.char_code  = s_axis_tdata[7:0];
    assign item_in.cell_color = s_axis_tdata[15:8];
    assign item_in.pos_x      = s_axis_tdata[22:16];
    assign item_in.pos_y      = s_axis_tdata[27:23];

    assign out_free = !out_valid_reg || m_axis_tready;

    tcw_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .item_in   (item_in),
        .attr      (attr_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.scrolled, out_reg.cell_entry, out_reg.hw_cursor_pos,
                            out_reg.write_row, out_reg.write_col};

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready
    ) else $error("input accepted on back-to-back cycles");

    a_scroll_position: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.scrolled |->
            (out_reg.write_col == '0) && (out_reg.write_row == LAST_ROW_OUT)
    ) else $error("scrolled result not at start of last row");

    a_result_load_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free
    ) else $error("result loaded over a waiting beat");

endmodule

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_walker.sv =====
`default_nettype none

// Address counter shared by the reset fill, clear, scroll copy and row blanking sweeps.
module tcw_walker #(
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic [$clog2(DEPTH)-1:0] first,
    input  wire logic [$clog2(DEPTH)-1:0] last,
    input  wire logic                     step,
    output logic      [$clog2(DEPTH)-1:0] addr,
    output logic                          at_end
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [AW-1:0] end_reg;
    logic [AW-1:0] end_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        end_next = end_reg;
        if (load)
        begin
            cnt_next = first;
            end_next = last;
        end
        else if (step && (cnt_reg != end_reg))
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Start at the reset fill sweep over the whole screen
            cnt_reg <= '0;
            end_reg <= AW'(DEPTH - 1);
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    assign addr   = cnt_reg;
    assign at_end = (cnt_reg == end_reg);

endmodule

`default_nettype wire

// ===== rtl/tcw_core.sv =====
`default_nettype none

module tcw_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire tcw_pkg::item_t                      item_in,
    input  wire logic [tcw_pkg::ATTR_W-1:0]          attr,
    input  wire logic                                out_free,
    output logic                                     res_valid,
    output tcw_pkg::result_t                         res,
    output logic                                     ram_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]          ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]               ram_wdata,
    output logic                                     ram_re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]          ram_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]          ram_rdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;
    tcw_pkg::item_t  item_reg;
    tcw_pkg::item_t  item_next;

    logic [RW-1:0]                row_reg;
    logic [RW-1:0]                row_next;
    logic [CW-1:0]                col_reg;
    logic [CW-1:0]                col_next;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_reg;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_next;
    logic [tcw_pkg::CELL_W-1:0]   entry_reg;
    logic [tcw_pkg::CELL_W-1:0]   entry_next;
    logic                         scrolled_reg;
    logic                         scrolled_next;
    logic                         cursor_after_reg;
    logic                         cursor_after_next;
    logic                         pend_reg;
    logic                         pend_next;
    logic [AW-1:0]                dst_reg;
    logic [AW-1:0]                dst_next;

    logic          walk_load;
    logic [AW-1:0] walk_first;
    logic [AW-1:0] walk_last;
    logic          walk_step;
    logic [AW-1:0] walk_addr;
    logic          walk_at_end;

    logic          sel_pos;
    logic [RW-1:0] mrow;
    logic [CW-1:0] mcol;
    logic [31:0]   lin32;
    logic [AW-1:0] lin;
    logic          on_screen;
    logic          last_col;
    logic          last_row;
    logic [31:0]   col_w;
    logic [31:0]   row_w;

    tcw_walker #(
        .DEPTH (CELLS)
    ) u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (walk_load),
        .first  (walk_first),
        .last   (walk_last),
        .step   (walk_step),
        .addr   (walk_addr),
        .at_end (walk_at_end)
    );

    // One shared row*COLUMNS+col unit for cell addresses and the cursor
    assign sel_pos = (state_reg == tcw_pkg::ST_EXEC) &&
                     ((item_reg.cmd == tcw_pkg::CMD_PUT_AT) ||
                      (item_reg.cmd == tcw_pkg::CMD_READ));
    assign mrow  = sel_pos ? RW'(item_reg.pos_y) : row_reg;
    assign mcol  = sel_pos ? CW'(item_reg.pos_x) : col_reg;
    assign lin32 = 32'(mrow) * 32'(COLUMNS) + 32'(mcol);
    assign lin   = lin32[AW-1:0];

    assign on_screen = (32'(item_reg.pos_x) < 32'(COLUMNS)) &&
                       (32'(item_reg.pos_y) < 32'(ROWS));
    assign last_col  = (col_reg == CW'(COLUMNS - 1));
    assign last_row  = (row_reg == RW'(ROWS - 1));

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        cursor_next       = cursor_reg;
        entry_next        = entry_reg;
        scrolled_next     = scrolled_reg;
        cursor_after_next = cursor_after_reg;
        pend_next         = 1'b0;
        dst_next          = dst_reg;
        walk_load         = 1'b0;
        walk_first        = '0;
        walk_last         = AW'(CELLS - 1);
        walk_step         = 1'b0;
        in_ready          = 1'b0;
        res_valid         = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = lin;
        ram_wdata         = {attr, item_reg.char_code};
        ram_re            = 1'b0;
        ram_raddr         = lin;

        // Retire the copy read issued in the cycle before
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = dst_reg;
            ram_wdata = ram_rdata;
        end

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = walk_addr;
                ram_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
                walk_step = 1'b1;
                if (walk_at_end)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = item_in;
                    state_next = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC:
            begin
                entry_next    = '0;
                scrolled_next = 1'b0;
                unique case (item_reg.cmd)
                    tcw_pkg::CMD_PUT_CURSOR:
                    begin
                        if (item_reg.char_code == tcw_pkg::CH_NEWLINE)
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                walk_load         = 1'b1;
                                walk_first        = AW'(COLUMNS);
                                scrolled_next     = 1'b1;
                                cursor_after_next = 1'b0;
                                state_next        = tcw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                row_next   = row_reg + RW'(1);
                                state_next = tcw_pkg::ST_DONE;
                            end
                        end
                        else if (item_reg.char_code == tcw_pkg::CH_BACKSPACE)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - CW'(1);
                            end
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - RW'(1);
                                col_next = CW'(COLUMNS - 1);
                            end
                            state_next = tcw_pkg::ST_CURSOR;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            if (last_col)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    walk_load         = 1'b1;
                                    walk_first        = AW'(COLUMNS);
                                    scrolled_next     = 1'b1;
                                    cursor_after_next = 1'b1;
                                    state_next        = tcw_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    row_next   = row_reg + RW'(1);
                                    state_next = tcw_pkg::ST_CURSOR;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + CW'(1);
                                state_next = tcw_pkg::ST_CURSOR;
                            end
                        end
                    end

                    tcw_pkg::CMD_PUT_AT:
                    begin
                        ram_we     = on_screen;
                        ram_wdata  = {item_reg.cell_color, item_reg.char_code};
                        state_next = tcw_pkg::ST_DONE;
                    end

                    tcw_pkg::CMD_CLEAR:
                    begin
                        walk_load   = 1'b1;
                        row_next    = '0;
                        col_next    = '0;
                        cursor_next = '0;
                        state_next  = tcw_pkg::ST_CLEAR;
                    end

                    tcw_pkg::CMD_READ:
                    begin
                        ram_re     = on_screen;
                        state_next = on_screen ? tcw_pkg::ST_RD_WAIT : tcw_pkg::ST_DONE;
                    end

                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end

            tcw_pkg::ST_RD_WAIT:
            begin
                entry_next = ram_rdata;
                state_next = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_SCROLL:
            begin
                // Read one row below, write it back one row up next cycle
                ram_re    = 1'b1;
                ram_raddr = walk_addr;
                pend_next = 1'b1;
                dst_next  = walk_addr - AW'(COLUMNS);
                walk_step = 1'b1;
                if (walk_at_end)
                begin
                    state_next = tcw_pkg::ST_FLUSH;
                end
            end

            tcw_pkg::ST_FLUSH:
            begin
                walk_load  = 1'b1;
                walk_first = AW'(CELLS - COLUMNS);
                state_next = tcw_pkg::ST_BLANK;
            end

            tcw_pkg::ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = walk_addr;
                ram_wdata = {attr, tcw_pkg::CH_SPACE};
                walk_step = 1'b1;
                if (walk_at_end)
                begin
                    row_next   = RW'(ROWS - 1);
                    col_next   = '0;
                    state_next = cursor_after_reg ? tcw_pkg::ST_CURSOR : tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = walk_addr;
                ram_wdata = {attr, tcw_pkg::CH_SPACE};
                walk_step = 1'b1;
                if (walk_at_end)
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_CURSOR:
            begin
                cursor_next = lin32[tcw_pkg::CURSOR_W-1:0];
                state_next  = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_DONE:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcw_pkg::ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            cursor_reg   <= '0;
            pend_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cursor_reg   <= cursor_next;
            pend_reg     <= pend_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        entry_reg        <= entry_next;
        cursor_after_reg <= cursor_after_next;
        dst_reg          <= dst_next;
    end

    assign col_w = 32'(col_reg);
    assign row_w = 32'(row_reg);

    assign res.write_col     = col_w[tcw_pkg::POSX_W-1:0];
    assign res.write_row     = row_w[tcw_pkg::POSY_W-1:0];
    assign res.hw_cursor_pos = cursor_reg;
    assign res.cell_entry    = entry_reg;
    assign res.scrolled      = scrolled_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    wire logic   cfg_ready;
    logic [7:0]  cfg_data = '0;

    text_console_writer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Mirror of the console state
    logic [CELL_W-1:0]   screen [CELLS];
    int                  cur_row;
    int                  cur_col;
    logic [CURSOR_W-1:0] cursor;
    logic [ATTR_W-1:0]   attr;

    item_t   pending_items [$];
    result_t expected_results [$];

    int items_loaded = 0;
    int items_taken  = 0;
    int errors       = 0;
    int send_idle    = 32;
    int recv_idle    = 46;
    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;

    function automatic void blank_screen(input logic [ATTR_W-1:0] a);
        for (int i = 0; i < CELLS; i++)
            screen[i] = {a, CH_SPACE};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < COLS * (ROWS - 1); i++)
            screen[i] = screen[i + COLS];
        for (int i = COLS * (ROWS - 1); i < CELLS; i++)
            screen[i] = {attr, CH_SPACE};
        cur_col = 0;
        cur_row = ROWS - 1;
    endfunction

    function automatic result_t console_step(input item_t it);
        result_t r;
        logic    scr;
        logic    on_screen;
        r = '0;
        scr = 1'b0;
        on_screen = (int'(it.pos_x) < COLS) && (int'(it.pos_y) < ROWS);
        case (it.cmd)
            CMD_PUT_CURSOR: begin
                if (it.char_code == CH_NEWLINE) begin
                    cur_row++;
                    if (cur_row >= ROWS) begin
                        scroll_screen();
                        scr = 1'b1;
                    end
                    cur_col = 0;
                end else begin
                    if (it.char_code == CH_BACKSPACE) begin
                        if (cur_col > 0) begin
                            cur_col--;
                        end else if (cur_row > 0) begin
                            cur_row--;
                            cur_col = COLS - 1;
                        end
                    end else begin
                        screen[cur_row * COLS + cur_col] = {attr, it.char_code};
                        cur_col++;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                            if (cur_row >= ROWS) begin
                                scroll_screen();
                                scr = 1'b1;
                            end
                        end
                    end
                    cursor = CURSOR_W'(cur_row * COLS + cur_col);
                end
            end
            CMD_PUT_AT: begin
                if (on_screen)
                    screen[int'(it.pos_y) * COLS + int'(it.pos_x)] =
                        {it.cell_color, it.char_code};
            end
            CMD_CLEAR: begin
                blank_screen(attr);
                cur_row = 0;
                cur_col = 0;
                cursor = '0;
            end
            default: begin
                if (on_screen)
                    r.cell_entry = screen[int'(it.pos_y) * COLS + int'(it.pos_x)];
            end
        endcase
        r.write_col     = POSX_W'(cur_col);
        r.write_row     = POSY_W'(cur_row);
        r.hw_cursor_pos = cursor;
        r.scrolled      = scr;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Monitor: track accepted beats on all three channels
    always @(posedge clk) begin : monitor
        item_t   it;
        result_t want;
        in_fire  <= s_axis_tvalid && s_axis_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (cfg_valid && cfg_ready)
            attr = cfg_data;
        if (s_axis_tvalid && s_axis_tready) begin
            it.cmd        = cmd_t'(s_axis_tuser);
            it.char_code  = s_axis_tdata[7:0];
            it.cell_color = s_axis_tdata[15:8];
            it.pos_x      = s_axis_tdata[22:16];
            it.pos_y      = s_axis_tdata[27:23];
            expected_results.push_back(console_step(it));
            items_taken++;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %0h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("write_col", 16'(want.write_col), 16'(m_axis_tdata[6:0]));
                check_field("write_row", 16'(want.write_row), 16'(m_axis_tdata[11:7]));
                check_field("hw_cursor_pos", 16'(want.hw_cursor_pos),
                            16'(m_axis_tdata[22:12]));
                check_field("cell_entry", want.cell_entry, m_axis_tdata[38:23]);
                check_field("scrolled", 16'(want.scrolled), 16'(m_axis_tdata[39]));
            end
        end
    end

    // Driver: hold a beat until taken, then load the next one or idle
    always @(negedge clk) begin : driver
        item_t nxt;
        if (rst_n && (!s_axis_tvalid || in_fire)) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, nxt.pos_y, nxt.pos_x, nxt.cell_color, nxt.char_code};
                s_axis_tuser  <= nxt.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic load(input cmd_t c, input logic [7:0] ch, input logic [7:0] color,
                        input int x, input int y);
        item_t it;
        it.cmd        = c;
        it.char_code  = ch;
        it.cell_color = color;
        it.pos_x      = POSX_W'(x);
        it.pos_y      = POSY_W'(y);
        pending_items.push_back(it);
        items_loaded++;
    endtask

    function automatic logic [7:0] rand_glyph();
        logic [7:0] c;
        c = 8'($urandom);
        while (c == CH_NEWLINE || c == CH_BACKSPACE)
            c = 8'($urandom);
        return c;
    endfunction

    task automatic write_attr(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (items_taken < items_loaded || expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Mostly text runs, newline and backspace runs; a few direct puts, reads and clears
    task automatic add_random(input int n);
        int added;
        int seg;
        int len;
        added = 0;
        while (added < n) begin
            seg = $urandom_range(0, 99);
            if (seg < 35) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 100)
                                                  : $urandom_range(1, 20);
                repeat (len)
                    load(CMD_PUT_CURSOR, rand_glyph(), 8'($urandom), $urandom, $urandom);
            end else if (seg < 50) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 30)
                                                  : $urandom_range(1, 6);
                repeat (len)
                    load(CMD_PUT_CURSOR, CH_NEWLINE, 8'($urandom), $urandom, $urandom);
            end else if (seg < 58) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(78, 90)
                                                  : $urandom_range(1, 6);
                repeat (len)
                    load(CMD_PUT_CURSOR, CH_BACKSPACE, 8'($urandom), $urandom, $urandom);
            end else if (seg < 75 || seg < 93) begin
                len = 1;
                if ($urandom_range(0, 9) == 0)
                    load(seg < 75 ? CMD_PUT_AT : CMD_READ, 8'($urandom), 8'($urandom),
                         $urandom, $urandom);
                else
                    load(seg < 75 ? CMD_PUT_AT : CMD_READ, 8'($urandom), 8'($urandom),
                         $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
            end else if (seg < 96) begin
                len = 1;
                load(CMD_CLEAR, 8'($urandom), 8'($urandom), $urandom, $urandom);
            end else begin
                len = 1;
                load(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                     $urandom, $urandom);
            end
            added += len;
        end
    endtask

    initial begin
        blank_screen(ATTR_RESET);
        attr    = ATTR_RESET;
        cur_row = 0;
        cur_col = 0;
        cursor  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        write_attr(8'hFF);
        load(CMD_READ, 8'($urandom), 8'($urandom), 0, 0);
        load(CMD_READ, 8'($urandom), 8'($urandom), COLS - 1, ROWS - 1);
        load(CMD_READ, 8'($urandom), 8'($urandom), COLS, 0);
        load(CMD_READ, 8'($urandom), 8'($urandom), 127, 31);
        load(CMD_PUT_AT, 8'h00, 8'hFF, COLS - 1, ROWS - 1);
        load(CMD_PUT_AT, 8'hFF, 8'h00, 0, 0);
        load(CMD_PUT_AT, 8'h41, 8'h12, 0, ROWS);
        load(CMD_PUT_AT, 8'h42, 8'h34, 127, 31);
        load(CMD_READ, 8'($urandom), 8'($urandom), COLS - 1, ROWS - 1);
        load(CMD_READ, 8'($urandom), 8'($urandom), 0, 0);
        load(CMD_READ, 8'($urandom), 8'($urandom), 0, ROWS - 1);
        // backspace at the top-left corner stays put
        load(CMD_PUT_CURSOR, CH_BACKSPACE, 8'($urandom), $urandom, $urandom);
        load(CMD_PUT_CURSOR, 8'h41, 8'($urandom), $urandom, $urandom);
        load(CMD_PUT_CURSOR, 8'h00, 8'($urandom), $urandom, $urandom);
        load(CMD_PUT_CURSOR, 8'hFF, 8'($urandom), $urandom, $urandom);
        load(CMD_PUT_CURSOR, CH_NEWLINE, 8'($urandom), $urandom, $urandom);
        // backspace at column 0 goes to the end of the previous row
        load(CMD_PUT_CURSOR, CH_BACKSPACE, 8'($urandom), $urandom, $urandom);
        load(CMD_PUT_CURSOR, 8'h5A, 8'($urandom), $urandom, $urandom);
        load(CMD_READ, 8'($urandom), 8'($urandom), COLS - 1, 0);
        load(CMD_READ, 8'($urandom), 8'($urandom), 1, 0);
        load(CMD_CLEAR, 8'($urandom), 8'($urandom), $urandom, $urandom);
        load(CMD_READ, 8'($urandom), 8'($urandom), COLS - 1, ROWS - 1);
        load(CMD_PUT_CURSOR, CH_BACKSPACE, 8'($urandom), $urandom, $urandom);

        drain();
        write_attr(8'h00);
        add_random(100);

        drain();
        send_idle = 46;
        recv_idle = 32;
        write_attr(8'($urandom));
        add_random(100);

        drain();
        send_idle = 0;
        recv_idle = 0;
        write_attr(8'($urandom));
        add_random(100);

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #8000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_walker.sv
rtl/tcw_core.sv
rtl/text_console_writer.sv
sim/tb.sv
